[rtl/core/rmst_pkg.sv]
// Shared types and constants for the range maximum segment tree.
// Holds the channel word layouts, the opcode codes and the sequencer states.
// No dependencies.
package rmst_pkg;

  localparam int VALUE_W = 31;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic   opcode;
    index_t element_index;
    value_t element_value;
    index_t range_low;
    index_t range_high;
  } in_word_t;

  typedef struct packed {
    value_t range_max;
    logic   index_error;
  } out_word_t;

  typedef struct packed {
    count_t element_count;
  } cfg_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W_LEAF,
    ST_W_RD,
    ST_W_UPD,
    ST_Q_LO,
    ST_Q_HI,
    ST_FIN
  } state_t;

endpackage

[rtl/core/rmst_if.sv]
// Valid/ready channel interfaces for the segment tree's input, result and
// configuration words. Depends on rmst_pkg.
interface rmst_in_if;
  import rmst_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rmst_out_if;
  import rmst_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rmst_cfg_if;
  import rmst_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/range_max_segment_tree.sv]
// Range maximum segment tree: point writes and inclusive range-max queries.
// Channels: in_chan takes one word per operation (opcode 0 writes
// element_value at element_index, opcode 1 queries [range_low, range_high]);
// out_chan returns exactly one word per operation (range_max, index_error);
// cfg_chan writes element_count, which saturates at MAX_ELEMENTS and clears
// the tree. Node maxima live in one RAM of 2*MAX_ELEMENTS words with leaves
// at MAX_ELEMENTS+i; one compare/max unit and the single RAM read port serve
// every step.
// Steps: a write does one leaf write, then a sibling read and a parent write
// per level up to the root. A query steps its low and high bounds up the
// tree level by level: the walk reads at most one node per cycle through the
// RAM port. Out-of-range writes and empty queries go straight to the
// result stage without touching the tree. in_chan.ready is high only
// between operations; a result waits in the output register, so the next
// word is taken while it is unread, and that word stalls at its end until
// the output register frees.
// Reset and each element_count write clear all 2*MAX_ELEMENTS words (2048
// by default) with in_chan.ready low; cfg_chan is always ready.
module range_max_segment_tree #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  rmst_in_if.sink           in_chan,
  rmst_out_if.source        out_chan,
  rmst_cfg_if.sink          cfg_chan
);
  import rmst_pkg::*;

  localparam int AW = $clog2(2 * MAX_ELEMENTS);
  localparam int KW = $clog2(2 * MAX_ELEMENTS + 1);
  localparam logic [16:0] MAX_E = 17'(MAX_ELEMENTS);
  localparam logic [AW-1:0] LAST_NODE = AW'(2 * MAX_ELEMENTS - 1);
  localparam logic [KW-1:0] LEAF_BASE = KW'(MAX_ELEMENTS);
  localparam logic [KW-1:0] ROOT = KW'(1);

  state_t          state_r, state_nxt;
  count_t          count_r, count_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic [KW-1:0]   lo_r, lo_nxt;
  logic [KW-1:0]   hi_r, hi_nxt;
  value_t          acc_r, acc_nxt;
  logic            pend_r, pend_nxt;
  logic            is_query_r, is_query_nxt;
  logic            err_r, err_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_data_r, out_data_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  value_t          ram_wdata;
  logic [AW-1:0]   ram_raddr;
  value_t          ram_rdata;

  logic            in_fire, cfg_fire, out_load;
  logic            wr_bad, q_empty;
  count_t          hi_clip;
  count_t          cfg_sat;
  value_t          cmp_max;

  rmst_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (2 * MAX_ELEMENTS)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign cfg_fire = cfg_chan.valid;
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_chan.ready);

  assign cfg_sat = ({6'b0, cfg_chan.data.element_count} > MAX_E) ?
                   MAX_E[COUNT_W-1:0] : cfg_chan.data.element_count;

  assign wr_bad  = {1'b0, in_chan.data.element_index} >= count_r;
  assign hi_clip = ({1'b0, in_chan.data.range_high} >= count_r) ?
                   count_r - 1'b1 : {1'b0, in_chan.data.range_high};
  // count of zero is covered by range_low >= count
  assign q_empty = ({1'b0, in_chan.data.range_low} >= count_r) ||
                   ({1'b0, in_chan.data.range_low} > hi_clip);

  // shared max unit
  assign cmp_max = (ram_rdata > acc_r) ? ram_rdata : acc_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == LAST_NODE) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_chan.data.opcode == OP_WRITE) begin
            state_nxt = wr_bad ? ST_FIN : ST_W_LEAF;
          end else begin
            state_nxt = q_empty ? ST_FIN : ST_Q_LO;
          end
        end
      end
      ST_W_LEAF: state_nxt = ST_W_RD;
      ST_W_RD: begin
        state_nxt = (k_r == ROOT) ? ST_FIN : ST_W_UPD;
      end
      ST_W_UPD: state_nxt = ST_W_RD;
      ST_Q_LO: begin
        state_nxt = (lo_r >= hi_r) ? ST_FIN : ST_Q_HI;
      end
      ST_Q_HI: state_nxt = ST_Q_LO;
      ST_FIN: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
    if (cfg_fire) state_nxt = ST_CLEAR;
  end

  always_comb begin
    count_nxt     = count_r;
    clr_cnt_nxt   = clr_cnt_r;
    k_nxt         = k_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    acc_nxt       = acc_r;
    pend_nxt      = 1'b0;
    is_query_nxt  = is_query_r;
    err_nxt       = err_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_fire) begin
          is_query_nxt = (in_chan.data.opcode == OP_QUERY);
          err_nxt      = (in_chan.data.opcode == OP_WRITE) && wr_bad;
          acc_nxt      = '0;
          if (in_chan.data.opcode == OP_WRITE) begin
            acc_nxt = in_chan.data.element_value;
            k_nxt   = LEAF_BASE + KW'(in_chan.data.element_index);
          end else begin
            lo_nxt = LEAF_BASE + KW'(in_chan.data.range_low);
            hi_nxt = LEAF_BASE + KW'(hi_clip) + ROOT;
          end
        end
      end
      ST_W_LEAF: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(k_r);
        ram_wdata = acc_r;
      end
      ST_W_RD: begin
        ram_raddr = AW'(k_r ^ ROOT);
      end
      ST_W_UPD: begin
        // the carried value equals the child we came from
        ram_we    = 1'b1;
        ram_waddr = AW'(k_r >> 1);
        ram_wdata = cmp_max;
        acc_nxt   = cmp_max;
        k_nxt     = k_r >> 1;
      end
      ST_Q_LO: begin
        if (pend_r) acc_nxt = cmp_max;
        if ((lo_r < hi_r) && lo_r[0]) begin
          ram_raddr = AW'(lo_r);
          lo_nxt    = lo_r + 1'b1;
          pend_nxt  = 1'b1;
        end
      end
      ST_Q_HI: begin
        if (pend_r) acc_nxt = cmp_max;
        if (hi_r[0]) begin
          ram_raddr = AW'(hi_r - 1'b1);
          pend_nxt  = 1'b1;
        end
        // for odd hi, (hi - 1) >> 1 equals hi >> 1
        lo_nxt = lo_r >> 1;
        hi_nxt = hi_r >> 1;
      end
      ST_FIN: begin
        if (out_load) begin
          out_data_nxt.range_max   = is_query_r ? acc_r : '0;
          out_data_nxt.index_error = err_r;
          out_valid_nxt            = 1'b1;
        end
      end
      default: begin
        clr_cnt_nxt = '0;
      end
    endcase

    if (cfg_fire) begin
      count_nxt   = cfg_sat;
      clr_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      count_r     <= '0;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    acc_r      <= acc_nxt;
    is_query_r <= is_query_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[rtl/core/rmst_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module rmst_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[verif/range_max_segment_tree_tb.sv]
// Self-checking testbench for range_max_segment_tree: point writes and range-max queries
// against an in-bench predictor, with bursty input, a stalling result side and element_count
// changes between phases. Depends on rmst_pkg and the rmst_*_if channel interfaces.
`timescale 1ns / 1ps

module range_max_segment_tree_tb;
  import rmst_pkg::*;

  localparam int MAX_ELEMENTS   = 1024;
  localparam int RANDOM_ITEMS   = 1550;
  localparam int WATCHDOG_LIMIT = 12000;
  localparam int TAIL_CYCLES    = 60;
  localparam value_t VALUE_MAX  = '1;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    in_word_t  word;
    logic      fixed;
    out_word_t result;
    count_t    count;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rmst_in_if  in_if ();
  rmst_out_if out_if ();
  rmst_cfg_if cfg_if ();

  range_max_segment_tree #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  always #5 clk = ~clk;

  // Predictor state: element values and the effective element count
  value_t    stored_val [MAX_ELEMENTS];
  int        live_count;
  out_word_t pending_results [$];
  stim_row_t directed_rows [$];
  int        err_count;
  int        burst_left;

  function automatic out_word_t apply_op(in_word_t w);
    out_word_t r;
    int        hi;
    r = '0;
    if (w.opcode == OP_WRITE) begin
      if (int'(w.element_index) >= live_count) r.index_error = 1'b1;
      else stored_val[w.element_index] = w.element_value;
    end else begin
      // clip to the elements in use; empty or reversed ranges leave the loop empty
      hi = int'(w.range_high);
      if (hi >= live_count) hi = live_count - 1;
      for (int i = int'(w.range_low); i <= hi; i++) begin
        if (stored_val[i] > r.range_max) r.range_max = stored_val[i];
      end
    end
    return r;
  endfunction

  function automatic void apply_count(count_t c);
    live_count = (int'(c) > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(c);
    foreach (stored_val[i]) stored_val[i] = '0;
  endfunction

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return VALUE_MAX;
      2:       return value_t'($urandom_range(0, 15));
      3:       return VALUE_MAX - value_t'($urandom_range(0, 15));
      default: return value_t'($urandom());
    endcase
  endfunction

  function automatic in_word_t make_item(int eff);
    in_word_t w;
    int       lo;
    w.opcode        = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_QUERY;
    w.element_index = index_t'($urandom_range(0, 1023));
    w.element_value = pick_value();
    w.range_low     = index_t'($urandom_range(0, 1023));
    w.range_high    = index_t'($urandom_range(0, 1023));
    if (eff > 0) begin
      if (w.opcode == OP_WRITE) begin
        if ($urandom_range(0, 9) < 8) w.element_index = index_t'($urandom_range(0, eff - 1));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            lo           = $urandom_range(0, eff - 1);
            w.range_low  = index_t'(lo);
            w.range_high = index_t'($urandom_range(lo, eff - 1));
          end
          6: begin
            lo           = $urandom_range(0, eff - 1);
            w.range_low  = index_t'(lo);
            w.range_high = index_t'(lo);
          end
          7: begin
            if (eff > 1) begin
              lo           = $urandom_range(1, eff - 1);
              w.range_low  = index_t'(lo);
              w.range_high = index_t'($urandom_range(0, lo - 1));
            end
          end
          default: ;
        endcase
      end
    end
    return w;
  endfunction

  task automatic row_item(logic op, int idx, value_t val, int lo, int hi,
                          logic fixed, value_t rmax, logic ierr);
    stim_row_t r;
    r.kind                  = ROW_ITEM;
    r.word.opcode           = op;
    r.word.element_index    = index_t'(idx);
    r.word.element_value    = val;
    r.word.range_low        = index_t'(lo);
    r.word.range_high       = index_t'(hi);
    r.fixed                 = fixed;
    r.result.range_max      = rmax;
    r.result.index_error    = ierr;
    r.count                 = '0;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  task automatic row_config(count_t c);
    stim_row_t r;
    r        = '{kind: ROW_CFG, word: '0, fixed: 1'b0, result: '0, count: c};
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // Drive one word, wait for its handshake, then possibly open a gap
  task automatic send_item(in_word_t w, logic fixed, out_word_t fixed_result);
    out_word_t predicted;
    int        gap;
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk); while (!in_if.ready);
    predicted = apply_op(w);
    pending_results.insert(pending_results.size(), fixed ? fixed_result : predicted);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 2);
        2:       gap = $urandom_range(3, 8);
        default: gap = $urandom_range(9, 20);
      endcase
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // With nothing outstanding the last gap has already dropped valid
  task automatic wait_results_drained();
    if (pending_results.size() != 0) begin
      in_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_count(count_t c);
    wait_results_drained();
    cfg_if.valid              <= 1'b1;
    cfg_if.data.element_count <= c;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    apply_count(c);
  endtask

  // Result side: stall on a pattern that changes every stretch of cycles
  initial begin
    int rx_mode;
    int mode_left;
    int rx_phase;
    rx_mode      = 0;
    mode_left    = 0;
    rx_phase     = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 150);
      end
      mode_left--;
      rx_phase++;
      case (rx_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 9) < 6);
        2:       out_if.ready <= (rx_phase % 3 == 0);
        default: out_if.ready <= (rx_phase % 32 >= 24);
      endcase
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: range_max %0d, index_error %0d",
               out_if.data.range_max, out_if.data.index_error);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.data.range_max !== want.range_max) begin
          $error("range_max: expected %0d, got %0d", want.range_max, out_if.data.range_max);
          err_count++;
        end
        if (out_if.data.index_error !== want.index_error) begin
          $error("index_error: expected %0d, got %0d",
                 want.index_error, out_if.data.index_error);
          err_count++;
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles without any handshake
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_word_t w;
    int       random_sent;
    int       eff;
    int       phase_len;
    int       n_build;
    count_t   c;

    err_count    = 0;
    burst_left   = 0;
    random_sent  = 0;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    apply_count('0);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // after reset: no elements, so queries give zero and writes are flagged
    row_item(OP_QUERY, 0, '0, 0, 1023, 1'b1, '0, 1'b0);
    row_item(OP_WRITE, 0, 5, 0, 0, 1'b1, '0, 1'b1);
    row_config(1024);
    row_item(OP_WRITE, 0, VALUE_MAX, 0, 0, 1'b1, '0, 1'b0);
    row_item(OP_WRITE, 1023, 1, 0, 0, 1'b1, '0, 1'b0);
    row_item(OP_QUERY, 0, '0, 0, 1023, 1'b1, VALUE_MAX, 1'b0);
    row_item(OP_QUERY, 0, '0, 1023, 1023, 1'b1, 1, 1'b0);
    row_item(OP_QUERY, 0, '0, 1023, 0, 1'b1, '0, 1'b0);
    row_item(OP_QUERY, 0, '0, 1, 1022, 1'b1, '0, 1'b0);
    row_item(OP_WRITE, 512, 1234, 0, 0, 1'b1, '0, 1'b0);
    row_item(OP_QUERY, 0, '0, 1, 1022, 1'b0, '0, 1'b0);
    row_item(OP_WRITE, 0, '0, 0, 0, 1'b1, '0, 1'b0);
    row_item(OP_QUERY, 0, '0, 0, 511, 1'b0, '0, 1'b0);
    // count above capacity saturates and clears the tree
    row_config(2047);
    row_item(OP_QUERY, 0, '0, 0, 1023, 1'b1, '0, 1'b0);
    row_item(OP_WRITE, 1023, 31'h2AAA_AAAA, 0, 0, 1'b1, '0, 1'b0);
    row_item(OP_QUERY, 0, '0, 1000, 1023, 1'b0, '0, 1'b0);
    // small count: out-of-range writes, clipped and empty ranges
    row_config(5);
    row_item(OP_WRITE, 5, 9, 0, 0, 1'b1, '0, 1'b1);
    row_item(OP_WRITE, 1023, VALUE_MAX, 0, 0, 1'b1, '0, 1'b1);
    row_item(OP_WRITE, 4, 31'h5555_5555, 0, 0, 1'b1, '0, 1'b0);
    row_item(OP_WRITE, 2, 77, 0, 0, 1'b1, '0, 1'b0);
    row_item(OP_QUERY, 0, '0, 0, 1023, 1'b0, '0, 1'b0);
    row_item(OP_QUERY, 0, '0, 5, 9, 1'b1, '0, 1'b0);
    row_item(OP_QUERY, 0, '0, 3, 2, 1'b1, '0, 1'b0);
    row_item(OP_QUERY, 0, '0, 2, 2, 1'b0, '0, 1'b0);
    row_config(1);
    row_item(OP_WRITE, 0, 42, 0, 0, 1'b1, '0, 1'b0);
    row_item(OP_QUERY, 0, '0, 0, 0, 1'b0, '0, 1'b0);
    row_config(0);
    row_item(OP_QUERY, 0, '0, 0, 0, 1'b1, '0, 1'b0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) write_count(directed_rows[i].count);
      else send_item(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].result);
    end

    // random phases: new count, a build of writes, then mixed traffic
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       c = '0;
        1:       c = count_t'(MAX_ELEMENTS);
        2:       c = count_t'($urandom_range(MAX_ELEMENTS + 1, 2047));
        3, 4:    c = count_t'($urandom_range(1, 8));
        5, 6, 7: c = count_t'($urandom_range(9, 64));
        default: c = count_t'($urandom_range(65, MAX_ELEMENTS - 1));
      endcase
      write_count(c);
      eff       = live_count;
      phase_len = (eff == 0) ? $urandom_range(10, 30) : $urandom_range(80, 200);
      n_build   = (eff < 24) ? eff : 24;
      for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
        w = make_item(eff);
        if (n < n_build) begin
          w.opcode        = OP_WRITE;
          w.element_index = (eff <= 24) ? index_t'(n) : index_t'($urandom_range(0, eff - 1));
        end
        // hold off the sender until every result is back
        if (n == phase_len / 2) wait_results_drained();
        send_item(w, 1'b0, '0);
        random_sent++;
      end
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
